// File: rtl/core/cmc_pkg.sv
// cover motion controller package: item, state and register types and codes
// used by the stream interface users, the update logic and the top level

package cmc_pkg;

  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_OPENING = 2'd1,
    OP_CLOSING = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ACT_STOPPED      = 3'd0,
    ACT_OPENING      = 3'd1,
    ACT_CLOSING      = 3'd2,
    ACT_SLOW_OPENING = 3'd3,
    ACT_SLOW_CLOSING = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_STOP          = 3'd1,
    EV_OPEN          = 3'd2,
    EV_CLOSE         = 3'd3,
    EV_ALMOST_OPEN   = 3'd4,
    EV_ALMOST_CLOSED = 3'd5,
    EV_FORCE_STOP    = 3'd6
  } ev_e;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_TARGET_MARGIN   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_SLOWDOWN_MARGIN = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_PUBLISH_IVL     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_STALL_TIMEOUT   = 3'd3;

  localparam logic [6:0] POS_FULL = 7'd100;

  typedef struct packed {
    logic               op;
    logic [31:0]        now_ms;
    logic signed [15:0] raw_position;
    logic               may_open;
    logic               may_close;
    logic               stop_request;
    logic               has_target;
    logic [6:0]         target_hundredths;
  } in_item_t;

  typedef struct packed {
    logic [6:0] position_hundredths;
    op_e        operation;
    act_e       drive_action;
    logic       publish;
    ev_e        drive_event;
  } out_item_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [31:0]         data;
  } cfg_item_t;

  typedef struct packed {
    logic [6:0]  target_margin;
    logic [6:0]  slowdown_margin;
    logic [31:0] publish_interval_ms;
    logic [31:0] stall_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  pos_now;
    logic [6:0]  pos_prev;
    logic [6:0]  target_pos;
    op_e         op;
    act_e        act;
    logic [31:0] last_move;
    logic [31:0] last_pub;
  } state_t;

endpackage

// File: rtl/core/cmc_stream_if.sv
// valid/ready stream channel carrying one payload of type T
// depends on nothing; payload types come from cmc_pkg at the instance

interface cmc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/cmc_step.sv
// combinational update of the cover sequencer for one request
// depends on cmc_pkg for state, register and item types

module cmc_step (
  input  cmc_pkg::state_t    state_i,
  input  cmc_pkg::cfg_t      cfg_i,
  input  cmc_pkg::in_item_t  item_i,
  output cmc_pkg::state_t    state_o,
  output cmc_pkg::out_item_t result_o
);
  import cmc_pkg::*;

  // clamp to 0..4096 and round (raw*100 + 2048) / 4096
  function automatic logic [6:0] to_hundredths(input logic signed [15:0] raw);
    logic [18:0] prod;
    prod = 19'({7'd0, raw[11:0]}) * 19'd100 + 19'd2048;
    if (raw[15] || (raw == 16'sd0)) begin
      return 7'd0;
    end else if (raw[14:12] != 3'd0) begin
      return POS_FULL;
    end else begin
      return prod[18:12];
    end
  endfunction

  logic [6:0]  pos;
  logic [6:0]  pos_err;
  logic [6:0]  tgt;
  logic [31:0] pub_age;
  logic [31:0] move_age;
  logic [31:0] move_time;
  logic        publish;
  ev_e         event_code;
  state_t      ns;

  assign pos      = to_hundredths(item_i.raw_position);
  assign pos_err  = (pos > state_i.target_pos) ? (pos - state_i.target_pos)
                                               : (state_i.target_pos - pos);
  assign tgt      = (item_i.target_hundredths > POS_FULL) ? POS_FULL
                                                          : item_i.target_hundredths;
  assign pub_age  = item_i.now_ms - state_i.last_pub;
  assign move_time = (state_i.pos_prev != pos) ? item_i.now_ms : state_i.last_move;
  assign move_age = item_i.now_ms - move_time;

  always_comb begin
    ns         = state_i;
    publish    = 1'b0;
    event_code = EV_NONE;
    if (!item_i.op) begin
      ns.pos_now = pos;
      if (pub_age > cfg_i.publish_interval_ms) begin
        publish     = 1'b1;
        ns.last_pub = item_i.now_ms;
      end
      if (state_i.op == OP_IDLE) begin
        if (state_i.act != ACT_STOPPED) begin
          event_code   = EV_STOP;
          ns.last_move = 32'd0;
          ns.act       = ACT_STOPPED;
        end
      end else begin
        ns.pos_prev  = pos;
        ns.last_move = move_time;
        if ((move_age > cfg_i.stall_timeout_ms) && (move_time != 32'd0)) begin
          ns.op      = OP_IDLE;
          ns.act     = ACT_STOPPED;
          publish    = 1'b1;
          event_code = EV_FORCE_STOP;
        end else if ((state_i.op == OP_OPENING && !item_i.may_open) ||
                     (state_i.op == OP_CLOSING && !item_i.may_close)) begin
          // movement not permitted: leave the drive alone
        end else if (pos_err <= cfg_i.target_margin) begin
          ns.op   = OP_IDLE;
          publish = 1'b1;
        end else if (pos_err <= cfg_i.slowdown_margin) begin
          if (state_i.op == OP_OPENING && state_i.act != ACT_SLOW_OPENING) begin
            event_code = EV_ALMOST_OPEN;
            ns.act     = ACT_SLOW_OPENING;
          end else if (state_i.op == OP_CLOSING && state_i.act != ACT_SLOW_CLOSING) begin
            event_code = EV_ALMOST_CLOSED;
            ns.act     = ACT_SLOW_CLOSING;
          end
        end else begin
          if (state_i.op == OP_OPENING && state_i.act != ACT_OPENING) begin
            event_code = EV_OPEN;
            ns.act     = ACT_OPENING;
          end else if (state_i.op == OP_CLOSING && state_i.act != ACT_CLOSING) begin
            event_code = EV_CLOSE;
            ns.act     = ACT_CLOSING;
          end
        end
      end
    end else begin
      if (item_i.stop_request) begin
        ns.op   = OP_IDLE;
        publish = 1'b1;
      end
      if (item_i.has_target && (tgt != state_i.pos_now)) begin
        ns.op         = (tgt < state_i.pos_now) ? OP_CLOSING : OP_OPENING;
        ns.target_pos = tgt;
        ns.last_move  = item_i.now_ms;
        publish       = 1'b1;
      end
    end
  end

  assign state_o = ns;

  always_comb begin
    result_o.position_hundredths = ns.pos_now;
    result_o.operation           = ns.op;
    result_o.drive_action        = ns.act;
    result_o.publish             = publish;
    result_o.drive_event         = event_code;
  end

endmodule

// File: rtl/core/cover_motion_controller_top.sv
// cover motion controller top level: request register, state and result registers
// depends on cmc_pkg, cmc_stream_if and cmc_step
//
// usage
//   in_i   : sink of cmc_stream_if carrying cmc_pkg::in_item_t (tick or command)
//   out_o  : source of cmc_stream_if carrying cmc_pkg::out_item_t, one per request
//   cfg_i  : sink of cmc_stream_if carrying cmc_pkg::cfg_item_t; always ready,
//            addresses 0..3 select target margin, slowdown margin, publish
//            interval and stall timeout, other addresses are dropped
// timing: a request taken is held in the request register, updated against the
//   state by cmc_step, and its result and the new state are registered once the
//   output register is free or out_o.ready is high
// throughput: one request per cycle while out_o takes results; the state update is
//   combinational logic between the request register and the state/result registers
// stall: a waiting result holds in the output register while one more request
//   is taken into the request register; in_i.ready drops only when both are full
// reset: rst_ni clears the channel valids and state (position 0, idle, stopped,
//   stall watch disarmed) and loads register defaults 1, 10, 1000 and 4000

module cover_motion_controller_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  cmc_stream_if.sink   in_i,
  cmc_stream_if.source out_o,
  cmc_stream_if.sink   cfg_i
);
  import cmc_pkg::*;

  in_item_t  req_q;
  logic      req_valid_q;
  out_item_t res_q;
  logic      res_valid_q;
  state_t    state_q;
  state_t    state_d;
  out_item_t res_d;
  cfg_t      cfg_q;
  logic      advance;

  assign advance     = req_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !req_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

  cmc_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (req_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_margin       <= 7'd1;
      cfg_q.slowdown_margin     <= 7'd10;
      cfg_q.publish_interval_ms <= 32'd1000;
      cfg_q.stall_timeout_ms    <= 32'd4000;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.addr)
        REG_TARGET_MARGIN:   cfg_q.target_margin       <= cfg_i.payload.data[6:0];
        REG_SLOWDOWN_MARGIN: cfg_q.slowdown_margin     <= cfg_i.payload.data[6:0];
        REG_PUBLISH_IVL:     cfg_q.publish_interval_ms <= cfg_i.payload.data;
        REG_STALL_TIMEOUT:   cfg_q.stall_timeout_ms    <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q.pos_now    <= 7'd0;
      state_q.pos_prev   <= 7'd0;
      state_q.target_pos <= 7'd0;
      state_q.op         <= OP_IDLE;
      state_q.act        <= ACT_STOPPED;
      state_q.last_move  <= 32'd0;
      state_q.last_pub   <= 32'd0;
    end else begin
      if (in_i.ready) begin
        req_valid_q <= in_i.valid;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q <= in_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  a_res_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.operation == state_q.op) && (res_q.drive_action == state_q.act) &&
                (res_q.position_hundredths == state_q.pos_now))
    else $error("result register out of step with sequencer state");

  a_force_stop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.drive_event == EV_FORCE_STOP) |=>
      (state_q.op == OP_IDLE) && (state_q.act == ACT_STOPPED) && res_q.publish)
    else $error("force stop did not idle the drive");

  a_stop_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.drive_event == EV_STOP) |=>
      (state_q.act == ACT_STOPPED) && (state_q.last_move == 32'd0))
    else $error("stop left the stall watch armed");

  a_full_take_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && in_i.valid && in_i.ready |-> advance)
    else $error("request register overwritten before it moved on");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.pos_now <= POS_FULL) && (state_q.target_pos <= POS_FULL))
    else $error("position or target above full travel");

endmodule
